// ===== rtl/esd_pkg.sv =====
package esd_pkg;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_CALL  = 2'd0,
		OP_MOVE  = 2'd1,
		OP_STAND = 2'd2
	} opcode_e;

	// Cabin commands carried on the result stream.
	typedef enum logic [2:0] {
		CMD_ON_FLOOR = 3'd0,
		CMD_MOVE     = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_OPEN     = 3'd3,
		CMD_IDLE     = 3'd4
	} cabin_cmd_e;

	// Dispatcher mode.
	typedef enum logic [1:0] {
		MODE_WAITING  = 2'd0,
		MODE_NEW_CALL = 2'd1,
		MODE_MOVING   = 2'd2,
		MODE_STANDING = 2'd3
	} mode_e;

	// Pending reaction in the event chain.
	typedef enum logic [1:0] {
		NX_NONE  = 2'd0,
		NX_MOVE  = 2'd1,
		NX_STAND = 2'd2,
		NX_WAIT  = 2'd3
	} next_e;

	// Where a finished sort hands control back to.
	typedef enum logic {
		RET_CALL = 1'b0,
		RET_MOVE = 1'b1
	} sort_ret_e;

	// Queue read address select.
	typedef enum logic [1:0] {
		RD_HEAD = 2'd0,
		RD_I    = 2'd1,
		RD_J    = 2'd2
	} rd_sel_e;

	// Controller states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DUP_RD,
		ST_DUP_CMP,
		ST_CALL_END,
		ST_DISPATCH,
		ST_MV_HRD,
		ST_MV_HCHK,
		ST_MV_STEP,
		ST_MV_EMIT,
		ST_MV_CNT,
		ST_MV_HCHK2,
		ST_ST_HRD,
		ST_ST_HCHK,
		ST_POP_RD,
		ST_POP_CMP,
		ST_SORT_I_RD,
		ST_SORT_I_LD,
		ST_SORT_J_RD,
		ST_SORT_J_CMP,
		ST_SORT_WR,
		ST_DRAIN
	} state_e;

	// Direction codes of a call.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Results kept per input item and the bound on chained reactions.
	localparam int unsigned MAX_RESULTS = 3;
	localparam logic [3:0]  GUARD_MAX   = 4'd8;

	// Queue entry: direction over floor.
	localparam int unsigned ENTRY_W = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       i_inc;
		logic       j_inc;
		logic       rd_en;
		rd_sel_e    rd_sel;
		logic       sort_init;
		logic       with_new;
		logic       ld_entry;
		logic       rank_cmp;
		logic       wr;
		logic       sort_fin;
		logic       pop;
		logic       step;
		logic       set_up;
		logic       up_val;
		logic       emit;
		cabin_cmd_e emit_cmd;
		logic       drain;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic floor_ok;
		logic full;
		logic cnt_zero;
		logic i_eq_cnt;
		logic dup_hit;
		logic i_done;
		logic j_done;
		logic i_new;
		logic j_new;
		logic cab_gt_hf;
		logic cab_lt_hf;
		logic cab_eq_hf;
		logic cab_eq_f;
		logic travel_up;
		logic res_any;
		logic out_last;
	} dp_stat_t;

	// Scan ordering key: same direction first, then the side ahead, then floor order.
	function automatic logic [5:0] sort_key(logic [3:0] f, logic [1:0] d, logic up,
			logic [3:0] cab);
		logic [1:0] cur;
		logic [1:0] eff;
		logic       g;
		logic       greater;
		logic       side;
		logic [3:0] fk;
		cur     = up ? DIR_UP : DIR_DOWN;
		eff     = (d == DIR_NONE) ? cur : d;
		g       = (eff != cur);
		greater = (f > cab);
		side    = up ? ~greater : greater;
		if (eff == DIR_UP) begin
			fk = greater ? f : 4'd15 - f;
		end else begin
			fk = greater ? 4'd15 - f : f;
		end
		return {g, side, fk};
	endfunction

endpackage

// ===== rtl/elevator_scan_dispatcher_core.sv =====
// Channel   Direction  Signals                       Contents
// s_axis    in         tvalid tready tdata[7:0]      call and cabin events
// m_axis    out        tvalid tready tdata[7:0] tlast cabin commands, tlast on the final one
//
// One event is taken at a time; its results (up to three) are sent before the next is taken.
// A move or standing check reads and tests the queue head; a standing check then pops the
// served entries, a read and a compare each. A call scans the queue for duplicates the same
// way and re-ranks it through the single read port of the queue memory, a pass over all
// n+1 entries for each entry; a reversal during a move pays the same pass over n entries.
// Reset clears the cabin to floor 0, travel up, empty queue; the queue memory needs no
// clearing. A stall on m_axis holds the current result and the block accepts nothing.
module elevator_scan_dispatcher_core #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned NUM_FLOORS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // opcode[1:0], call_floor[5:2], call_direction[7:6]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // command[2:0], floor_report[6:3], zero[7]
	output logic       m_axis_tlast
);
	import esd_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t st;

	// Sequencing of calls, moves, stops and the queue sort.
	esd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.opcode    (s_axis_tdata[1:0]),
		.out_ready (m_axis_tready),
		.st        (st),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	// Cabin position, queue memory and result slots.
	esd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_FLOORS  (NUM_FLOORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.st        (st),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== rtl/esd_ram.sv =====
module esd_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/esd_datapath.sv =====
module esd_datapath #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned NUM_FLOORS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_data,
	input  logic             out_ready,
	input  esd_pkg::ctl_cmd_t cmd,
	output esd_pkg::dp_stat_t st,
	output logic [7:0]       out_data,
	output logic             out_last
);
	import esd_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [3:0] TOP_FLOOR = (NUM_FLOORS - 1 > 15) ? 4'd15 : 4'(NUM_FLOORS - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// Control state.
	logic [3:0]    cabin_q;
	logic          up_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic          bank_q;
	logic          with_new_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] rank_q;
	logic [1:0]    res_n_q;
	logic [1:0]    out_idx_q;

	// Payload registers.
	logic [3:0]         f_q;
	logic [1:0]         d_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [5:0]         key_i_q;
	logic [2:0]         res_cmd_q   [MAX_RESULTS];
	logic [3:0]         res_floor_q [MAX_RESULTS];

	logic [CW-1:0]      n_items;
	logic [CW:0]        addr_sum;
	logic [CW-1:0]      addr_off;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd0;
	logic [ENTRY_W-1:0] rd1;
	logic [ENTRY_W-1:0] rd_data;
	logic [3:0]         hf;
	logic [ENTRY_W-1:0] new_entry;
	logic [ENTRY_W-1:0] cur_j;
	logic [5:0]         key_j;
	logic [1:0]         in_dir;

	assign n_items   = count_q + CW'(with_new_q);
	assign new_entry = {d_q, f_q};
	assign in_dir    = (in_data[7:6] > DIR_DOWN) ? DIR_NONE : in_data[7:6];

	// Queue read address: head plus a scan index.
	always_comb begin
		case (cmd.rd_sel)
			RD_I:    addr_off = i_q;
			RD_J:    addr_off = j_q;
			default: addr_off = '0;
		endcase
		addr_sum = (CW + 1)'(head_q) + (CW + 1)'(addr_off);
		rd_addr  = addr_sum[AW-1:0];
	end

	// Two banks: read from the live one, a sort writes the other.
	esd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram0 (
		.clk   (clk),
		.we    (cmd.wr && bank_q),
		.waddr (rank_q[AW-1:0]),
		.wdata (entry_q),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	esd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram1 (
		.clk   (clk),
		.we    (cmd.wr && !bank_q),
		.waddr (rank_q[AW-1:0]),
		.wdata (entry_q),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	assign rd_data = bank_q ? rd1 : rd0;
	assign hf      = rd_data[3:0];
	assign cur_j   = (with_new_q && j_q == count_q) ? new_entry : rd_data;
	assign key_j   = sort_key(cur_j[3:0], cur_j[5:4], up_q, cabin_q);

	// Status toward the controller.
	always_comb begin
		st.floor_ok  = (32'(f_q) < NUM_FLOORS);
		st.full      = (count_q == DEPTH_C);
		st.cnt_zero  = (count_q == '0);
		st.i_eq_cnt  = (i_q == count_q);
		st.dup_hit   = (rd_data == new_entry);
		st.i_done    = (i_q == n_items);
		st.j_done    = (j_q == n_items);
		st.i_new     = with_new_q && (i_q == count_q);
		st.j_new     = with_new_q && (j_q == count_q);
		st.cab_gt_hf = (cabin_q > hf);
		st.cab_lt_hf = (cabin_q < hf);
		st.cab_eq_hf = (cabin_q == hf);
		st.cab_eq_f  = (cabin_q == f_q);
		st.travel_up = up_q;
		st.res_any   = (res_n_q != '0);
		st.out_last  = (out_idx_q == res_n_q - 2'd1);
	end

	// Cabin, queue bookkeeping and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cabin_q    <= '0;
			up_q       <= 1'b1;
			count_q    <= '0;
			head_q     <= '0;
			bank_q     <= 1'b0;
			with_new_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			rank_q     <= '0;
			res_n_q    <= '0;
			out_idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				i_q       <= '0;
				res_n_q   <= '0;
				out_idx_q <= '0;
			end
			if (cmd.i_inc) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.sort_init) begin
				with_new_q <= cmd.with_new;
				i_q        <= '0;
			end
			if (cmd.ld_entry) begin
				j_q    <= '0;
				rank_q <= '0;
			end
			if (cmd.j_inc) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.rank_cmp && (key_j < key_i_q || (key_j == key_i_q && j_q < i_q))) begin
				rank_q <= rank_q + CW'(1);
			end
			if (cmd.sort_fin) begin
				count_q    <= n_items;
				head_q     <= '0;
				bank_q     <= !bank_q;
				with_new_q <= 1'b0;
			end
			if (cmd.pop) begin
				head_q  <= head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end
			if (cmd.set_up) begin
				up_q <= cmd.up_val;
			end
			if (cmd.step) begin
				if (up_q) begin
					if (cabin_q < TOP_FLOOR) begin
						cabin_q <= cabin_q + 4'd1;
					end
				end else if (cabin_q != 4'd0) begin
					cabin_q <= cabin_q - 4'd1;
				end
			end
			if (cmd.emit && res_n_q != 2'(MAX_RESULTS)) begin
				res_n_q <= res_n_q + 2'd1;
			end
			if (cmd.drain && out_ready) begin
				out_idx_q <= out_idx_q + 2'd1;
			end
		end
	end

	// Payload capture: call fields, sort entry and result slots.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q <= in_data[5:2];
			d_q <= in_dir;
		end
		if (cmd.ld_entry) begin
			entry_q <= st.i_new ? new_entry : rd_data;
			key_i_q <= st.i_new ? sort_key(f_q, d_q, up_q, cabin_q)
			                    : sort_key(rd_data[3:0], rd_data[5:4], up_q, cabin_q);
		end
		if (cmd.emit && res_n_q != 2'(MAX_RESULTS)) begin
			res_cmd_q[res_n_q]   <= cmd.emit_cmd;
			res_floor_q[res_n_q] <= cabin_q;
		end
	end

	assign out_data = {1'b0, res_floor_q[out_idx_q], res_cmd_q[out_idx_q]};
	assign out_last = st.out_last;

endmodule

// ===== rtl/esd_ctrl.sv =====
module esd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        opcode,
	input  logic              out_ready,
	input  esd_pkg::dp_stat_t st,
	output logic              in_ready,
	output logic              out_valid,
	output esd_pkg::ctl_cmd_t cmd
);
	import esd_pkg::*;

	state_e    state_q, state_d;
	mode_e     mode_q, mode_d;
	mode_e     was_q, was_d;
	next_e     nxt_q, nxt_d;
	logic [3:0] guard_q, guard_d;
	sort_ret_e ret_q, ret_d;
	opcode_e   op;

	assign op = opcode_e'(opcode);

	// State and chain bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_WAITING;
			was_q   <= MODE_WAITING;
			nxt_q   <= NX_NONE;
			guard_q <= '0;
			ret_q   <= RET_CALL;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			was_q   <= was_d;
			nxt_q   <= nxt_d;
			guard_q <= guard_d;
			ret_q   <= ret_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		was_d   = was_q;
		nxt_d   = nxt_q;
		guard_d = guard_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					guard_d = '0;
					case (op)
						OP_CALL: begin
							was_d   = mode_q;
							mode_d  = MODE_NEW_CALL;
							state_d = ST_DUP_RD;
						end
						OP_MOVE: begin
							nxt_d   = NX_MOVE;
							state_d = ST_DISPATCH;
						end
						OP_STAND: begin
							nxt_d   = NX_STAND;
							state_d = ST_DISPATCH;
						end
						default: ;
					endcase
				end
			end
			ST_DUP_RD: begin
				if (!st.floor_ok) begin
					state_d = ST_CALL_END;
				end else if (st.i_eq_cnt) begin
					if (st.full) begin
						state_d = ST_CALL_END;
					end else begin
						ret_d   = RET_CALL;
						state_d = ST_SORT_I_RD;
					end
				end else begin
					state_d = ST_DUP_CMP;
				end
			end
			ST_DUP_CMP: state_d = st.dup_hit ? ST_CALL_END : ST_DUP_RD;
			ST_CALL_END: begin
				if (st.cab_eq_f) begin
					nxt_d = NX_STAND;
				end else if (was_q == MODE_WAITING) begin
					nxt_d = NX_MOVE;
				end else begin
					nxt_d = NX_NONE;
				end
				state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (nxt_q == NX_NONE || guard_q == GUARD_MAX) begin
					state_d = st.res_any ? ST_DRAIN : ST_IDLE;
				end else begin
					guard_d = guard_q + 4'd1;
					case (nxt_q)
						NX_MOVE: begin
							if (mode_q == MODE_WAITING) begin
								nxt_d = NX_NONE;
							end else begin
								was_d   = mode_q;
								mode_d  = MODE_MOVING;
								state_d = st.cnt_zero ? ST_MV_STEP : ST_MV_HRD;
							end
						end
						NX_STAND: begin
							if (mode_q == MODE_WAITING) begin
								nxt_d = NX_NONE;
							end else begin
								was_d  = mode_q;
								mode_d = MODE_STANDING;
								if (st.cnt_zero) begin
									nxt_d = NX_WAIT;
								end else begin
									state_d = ST_ST_HRD;
								end
							end
						end
						default: begin
							if (mode_q == MODE_MOVING || mode_q == MODE_STANDING) begin
								mode_d = MODE_WAITING;
							end
							nxt_d = NX_NONE;
						end
					endcase
				end
			end
			ST_MV_HRD: state_d = ST_MV_HCHK;
			ST_MV_HCHK: begin
				if ((st.cab_gt_hf && st.travel_up) || (st.cab_lt_hf && !st.travel_up)) begin
					ret_d   = RET_MOVE;
					state_d = ST_SORT_I_RD;
				end else begin
					state_d = ST_MV_STEP;
				end
			end
			ST_MV_STEP: begin
				if (was_q == MODE_MOVING || was_q == MODE_NEW_CALL) begin
					state_d = ST_MV_EMIT;
				end else begin
					state_d = ST_MV_CNT;
				end
			end
			ST_MV_EMIT: state_d = ST_MV_CNT;
			ST_MV_CNT: begin
				if (st.cnt_zero) begin
					nxt_d   = NX_WAIT;
					state_d = ST_DISPATCH;
				end else begin
					state_d = ST_MV_HCHK2;
				end
			end
			ST_MV_HCHK2: begin
				nxt_d   = st.cab_eq_hf ? NX_STAND : NX_NONE;
				state_d = ST_DISPATCH;
			end
			ST_ST_HRD: state_d = ST_ST_HCHK;
			ST_ST_HCHK: begin
				if (st.cab_eq_hf) begin
					state_d = ST_POP_RD;
				end else begin
					nxt_d   = NX_MOVE;
					state_d = ST_DISPATCH;
				end
			end
			ST_POP_RD: begin
				if (st.cnt_zero) begin
					nxt_d   = NX_NONE;
					state_d = ST_DISPATCH;
				end else begin
					state_d = ST_POP_CMP;
				end
			end
			ST_POP_CMP: begin
				if (st.cab_eq_hf) begin
					state_d = ST_POP_RD;
				end else begin
					nxt_d   = NX_NONE;
					state_d = ST_DISPATCH;
				end
			end
			ST_SORT_I_RD: begin
				if (st.i_done) begin
					state_d = (ret_q == RET_CALL) ? ST_CALL_END : ST_MV_STEP;
				end else begin
					state_d = ST_SORT_I_LD;
				end
			end
			ST_SORT_I_LD: state_d = ST_SORT_J_RD;
			ST_SORT_J_RD: state_d = st.j_done ? ST_SORT_WR : ST_SORT_J_CMP;
			ST_SORT_J_CMP: state_d = ST_SORT_J_RD;
			ST_SORT_WR: state_d = ST_SORT_I_RD;
			ST_DRAIN: begin
				if (out_ready && st.out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands and handshake outputs.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DUP_RD: begin
				if (st.floor_ok && st.i_eq_cnt && !st.full) begin
					cmd.sort_init = 1'b1;
					cmd.with_new  = 1'b1;
				end else if (st.floor_ok && !st.i_eq_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_I;
				end
			end
			ST_DUP_CMP: cmd.i_inc = !st.dup_hit;
			ST_DISPATCH: begin
				if (nxt_q == NX_WAIT && guard_q != GUARD_MAX &&
						(mode_q == MODE_MOVING || mode_q == MODE_STANDING)) begin
					cmd.emit     = 1'b1;
					cmd.emit_cmd = CMD_IDLE;
				end
			end
			ST_MV_HRD, ST_ST_HRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_HEAD;
			end
			ST_MV_HCHK: begin
				if (st.cab_gt_hf && st.travel_up) begin
					cmd.set_up    = 1'b1;
					cmd.up_val    = 1'b0;
					cmd.sort_init = 1'b1;
				end else if (st.cab_lt_hf && !st.travel_up) begin
					cmd.set_up    = 1'b1;
					cmd.up_val    = 1'b1;
					cmd.sort_init = 1'b1;
				end
			end
			ST_MV_STEP: cmd.step = (was_q == MODE_MOVING || was_q == MODE_NEW_CALL);
			ST_MV_EMIT: begin
				cmd.emit     = 1'b1;
				cmd.emit_cmd = CMD_ON_FLOOR;
			end
			ST_MV_CNT: begin
				cmd.rd_en  = !st.cnt_zero;
				cmd.rd_sel = RD_HEAD;
			end
			ST_MV_HCHK2: begin
				cmd.emit     = !st.cab_eq_hf;
				cmd.emit_cmd = CMD_MOVE;
			end
			ST_ST_HCHK: cmd.pop = st.cab_eq_hf;
			ST_POP_RD: begin
				if (st.cnt_zero) begin
					cmd.emit     = 1'b1;
					cmd.emit_cmd = (was_q == MODE_MOVING) ? CMD_STOP : CMD_OPEN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HEAD;
				end
			end
			ST_POP_CMP: begin
				if (st.cab_eq_hf) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.emit     = 1'b1;
					cmd.emit_cmd = (was_q == MODE_MOVING) ? CMD_STOP : CMD_OPEN;
				end
			end
			ST_SORT_I_RD: begin
				if (st.i_done) begin
					cmd.sort_fin = 1'b1;
				end else begin
					cmd.rd_en  = !st.i_new;
					cmd.rd_sel = RD_I;
				end
			end
			ST_SORT_I_LD: cmd.ld_entry = 1'b1;
			ST_SORT_J_RD: begin
				cmd.rd_en  = !st.j_done && !st.j_new;
				cmd.rd_sel = RD_J;
			end
			ST_SORT_J_CMP: begin
				cmd.rank_cmp = 1'b1;
				cmd.j_inc    = 1'b1;
			end
			ST_SORT_WR: begin
				cmd.wr    = 1'b1;
				cmd.i_inc = 1'b1;
			end
			ST_DRAIN: begin
				out_valid = 1'b1;
				cmd.drain = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/elevator_scan_dispatcher_core_test.sv =====
`timescale 1ns / 100ps

module elevator_scan_dispatcher_core_test;
	import esd_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned FLOORS = 16;
	localparam logic [3:0] TOP = 4'd15;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] DIR_RESERVED = 2'd3;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 1500;

	typedef struct packed {
		cabin_cmd_e cmd;
		logic [3:0] flr;
		logic       last;
	} cabin_result_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	elevator_scan_dispatcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// Dispatcher state as the predictor sees it.
	mode_e       disp_mode;
	logic        going_up;
	logic [3:0]  cab;
	logic [3:0]  call_flr [DEPTH];
	logic [1:0]  call_dir [DEPTH];
	int unsigned calls_held;
	cabin_cmd_e  step_cmd [MAX_RESULTS];
	logic [3:0]  step_flr [MAX_RESULTS];
	int unsigned step_n;

	// Expected results in order, as a ring with wrapping indexes.
	cabin_result_t exp_ring [256];
	logic [7:0]    exp_wr;
	logic [7:0]    exp_rd;
	int unsigned   mismatches;
	int unsigned   burst_left;
	int unsigned   hold_off;
	int unsigned   idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Scan ordering key of one queued call.
	function automatic logic [5:0] scan_rank(logic [3:0] f, logic [1:0] d);
		logic [1:0] cur;
		logic [1:0] eff;
		logic       ahead;
		logic [3:0] fk;
		cur = going_up ? DIR_UP : DIR_DOWN;
		eff = (d == DIR_NONE) ? cur : d;
		ahead = (f > cab);
		if (eff == DIR_UP) begin
			fk = ahead ? f : 4'd15 - f;
		end else begin
			fk = ahead ? 4'd15 - f : f;
		end
		return {eff != cur, going_up ? ~ahead : ahead, fk};
	endfunction

	// Stable insertion sort of the held calls.
	function automatic void rerank_calls();
		int j;
		logic [3:0] f;
		logic [1:0] d;
		for (int i = 1; i < calls_held; i++) begin
			f = call_flr[i];
			d = call_dir[i];
			j = i;
			while (j > 0 && scan_rank(call_flr[j-1], call_dir[j-1]) > scan_rank(f, d)) begin
				call_flr[j] = call_flr[j-1];
				call_dir[j] = call_dir[j-1];
				j--;
			end
			call_flr[j] = f;
			call_dir[j] = d;
		end
	endfunction

	function automatic void note_result(cabin_cmd_e c);
		if (step_n < MAX_RESULTS) begin
			step_cmd[step_n] = c;
			step_flr[step_n] = cab;
			step_n++;
		end
	endfunction

	function automatic void add_call(logic [3:0] f, logic [1:0] d);
		if (f >= FLOORS) return;
		for (int i = 0; i < calls_held; i++)
			if (call_flr[i] == f && call_dir[i] == d) return;
		if (calls_held >= DEPTH) return;
		call_flr[calls_held] = f;
		call_dir[calls_held] = d;
		calls_held++;
		rerank_calls();
	endfunction

	function automatic next_e go_idle();
		if (disp_mode == MODE_MOVING || disp_mode == MODE_STANDING) begin
			disp_mode = MODE_WAITING;
			note_result(CMD_IDLE);
		end
		return NX_NONE;
	endfunction

	function automatic next_e step_cabin();
		mode_e was;
		if (disp_mode == MODE_WAITING) return NX_NONE;
		was = disp_mode;
		disp_mode = MODE_MOVING;
		// Reverse when the head target lies behind the cabin.
		if (calls_held > 0) begin
			if (cab > call_flr[0] && going_up) begin
				going_up = 1'b0;
				rerank_calls();
			end else if (cab < call_flr[0] && !going_up) begin
				going_up = 1'b1;
				rerank_calls();
			end
		end
		if (was == MODE_MOVING || was == MODE_NEW_CALL) begin
			if (going_up) begin
				if (cab < TOP) cab++;
			end else begin
				if (cab > 0) cab--;
			end
			note_result(CMD_ON_FLOOR);
		end
		if (calls_held == 0) return NX_WAIT;
		if (cab == call_flr[0]) return NX_STAND;
		note_result(CMD_MOVE);
		return NX_NONE;
	endfunction

	function automatic next_e stand_cabin();
		mode_e was;
		if (disp_mode == MODE_WAITING) return NX_NONE;
		was = disp_mode;
		disp_mode = MODE_STANDING;
		if (calls_held == 0) return NX_WAIT;
		if (cab != call_flr[0]) return NX_MOVE;
		// Serve every call held for this floor.
		while (calls_held > 0 && cab == call_flr[0]) begin
			for (int i = 1; i < calls_held; i++) begin
				call_flr[i-1] = call_flr[i];
				call_dir[i-1] = call_dir[i];
			end
			calls_held--;
		end
		note_result(was == MODE_MOVING ? CMD_STOP : CMD_OPEN);
		return NX_NONE;
	endfunction

	// Works out the cabin commands caused by one accepted event.
	function automatic void predict_commands(logic [1:0] op, logic [3:0] f, logic [1:0] d);
		next_e nx;
		mode_e was;
		cabin_result_t r;
		nx = NX_NONE;
		step_n = 0;
		if (d == DIR_RESERVED) d = DIR_NONE;
		if (op == OP_CALL) begin
			was = disp_mode;
			disp_mode = MODE_NEW_CALL;
			add_call(f, d);
			if (cab == f) nx = NX_STAND;
			else if (was == MODE_WAITING) nx = NX_MOVE;
		end else if (op == OP_MOVE) begin
			nx = NX_MOVE;
		end else if (op == OP_STAND) begin
			nx = NX_STAND;
		end
		for (int g = 0; g < GUARD_MAX && nx != NX_NONE; g++) begin
			case (nx)
				NX_MOVE: begin
					nx = step_cabin();
				end
				NX_STAND: begin
					nx = stand_cabin();
				end
				default: begin
					nx = go_idle();
				end
			endcase
		end
		for (int i = 0; i < step_n; i++) begin
			r.cmd = step_cmd[i];
			r.flr = step_flr[i];
			r.last = (i == step_n - 1);
			exp_ring[exp_wr] = r;
			exp_wr++;
		end
	endfunction

	// Sends one event in bursts with random gaps; called at a falling edge.
	task automatic send_event(logic [1:0] op, logic [3:0] f, logic [1:0] d);
		int unsigned gap;
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {d, f, op};
		do @(posedge clk); while (!s_axis_tready);
		predict_commands(op, f, d);
		@(negedge clk);
	endtask

	task automatic send_random_noise();
		send_event(2'($urandom_range(0, 3)), 4'($urandom), 2'($urandom));
	endtask

	task automatic wait_all_served();
		s_axis_tvalid = 1'b0;
		while (exp_wr != exp_rd) @(negedge clk);
	endtask

	// Events while waiting, the unused opcode and the unused direction.
	task automatic test_idle_events();
		send_event(OP_MOVE, 4'd3, DIR_UP);
		send_event(OP_STAND, 4'd15, DIR_DOWN);
		send_event(OP_UNUSED, 4'd9, DIR_RESERVED);
		send_event(OP_CALL, 4'd0, DIR_RESERVED);
		send_event(OP_CALL, 4'd15, DIR_UP);
	endtask

	// Fills the queue past full with duplicates and every direction.
	task automatic test_fill_queue();
		for (int i = 1; i <= 17; i++)
			send_event(OP_CALL, 4'(i % 16), 2'(i % 3));
		send_event(OP_CALL, 4'd1, DIR_UP);
	endtask

	// Moves and standing checks until the cabin has served the queue.
	task automatic test_service_trips();
		for (int i = 0; i < 45; i++)
			send_event(i % 3 == 2 ? OP_STAND : OP_MOVE, 4'd0, DIR_NONE);
		wait_all_served();
	endtask

	// Long receiver hold-off while events keep coming, then a full drain.
	task automatic test_backpressure();
		hold_off = 400;
		for (int i = 0; i < 8; i++)
			send_event(i < 4 ? OP_CALL : OP_MOVE, 4'($urandom), 2'($urandom_range(0, 2)));
		wait_all_served();
	endtask

	// Mostly call bursts followed by trips, with some noise.
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned k;
		sent = 0;
		while (sent < 35) begin
			if ($urandom_range(0, 9) < 8) begin
				k = $urandom_range(1, 4);
				repeat (k) send_event(OP_CALL, 4'($urandom), 2'($urandom));
				sent += k;
				k = $urandom_range(3, 12);
				repeat (k) begin
					send_event($urandom_range(0, 4) < 3 ? OP_MOVE : OP_STAND, 4'($urandom),
						2'($urandom));
				end
				sent += k;
			end else begin
				send_random_noise();
				sent++;
			end
		end
	endtask

	// Receiver ready pattern: free-running, random, or mostly stalled stretches.
	initial begin
		int unsigned style;
		int unsigned left;
		m_axis_tready = 1'b0;
		style = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready = 1'b0;
				hold_off--;
			end else begin
				if (left == 0) begin
					style = $urandom_range(0, 2);
					left = $urandom_range(5, 60);
				end
				left--;
				case (style)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = $urandom_range(0, 1);
					default: m_axis_tready = ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		cabin_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result cmd=%0d floor=%0d last=%0b",
						m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tlast);
			end else begin
				want = exp_ring[exp_rd];
				exp_rd++;
				if (m_axis_tdata[2:0] !== want.cmd || m_axis_tdata[6:3] !== want.flr ||
						m_axis_tdata[7] !== 1'b0 || m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected cmd=%0d floor=%0d last=%0b, got %0d %0d %0b",
							want.cmd, want.flr, want.last, m_axis_tdata[2:0],
							m_axis_tdata[6:3], m_axis_tlast);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[elevator_scan_dispatcher_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		mismatches = 0;
		burst_left = 0;
		hold_off = 0;
		idle_cycles = 0;
		exp_wr = '0;
		exp_rd = '0;
		disp_mode = MODE_WAITING;
		going_up = 1'b1;
		cab = 4'd0;
		calls_held = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_idle_events();
		test_fill_queue();
		test_service_trips();
		test_backpressure();
		test_random_traffic();
		wait_all_served();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && exp_wr == exp_rd) begin
			$display("[elevator_scan_dispatcher_core] OK");
		end else begin
			$display("[elevator_scan_dispatcher_core] ERROR");
		end
		$finish;
	end

endmodule
